// File: src/icsp_pkg.sv
package icsp_pkg;

    localparam int DATA_W        = 14;
    localparam int WORD_BITS_DEF = 14;
    localparam int CMD_BITS      = 6;
    localparam int Q_DEPTH       = 2;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 24;

    typedef enum logic [2:0] {
        OP_LOAD_CFG   = 3'd0,
        OP_LOAD_DATA  = 3'd1,
        OP_READ_DATA  = 3'd2,
        OP_INCREMENT  = 3'd3,
        OP_ERASE_PROG = 3'd4,
        OP_BULK_ERASE = 3'd5,
        OP_SAMPLE     = 3'd6
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] word;
        logic              pin;
    } t_item;

    typedef struct packed {
        logic              drive_enable;
        logic              data_bit;
        logic              word_valid;
        logic [DATA_W-1:0] read_word;
        logic              match;
        logic              last;
    } t_slot;

    // Command codes, bit 0 goes out first.
    function automatic logic [CMD_BITS-1:0] cmd_code(input t_op op);
        logic [CMD_BITS-1:0] code;
        case (op)
            OP_LOAD_CFG:   code = 6'h00;
            OP_LOAD_DATA:  code = 6'h02;
            OP_READ_DATA:  code = 6'h04;
            OP_INCREMENT:  code = 6'h06;
            OP_ERASE_PROG: code = 6'h08;
            OP_BULK_ERASE: code = 6'h09;
            default:       code = 6'h00;
        endcase
        return code;
    endfunction

endpackage

// File: src/icsp_programming_serializer_core.sv
// Channel  | Dir | Transfer carries
// s_axis   | in  | tuser: operation[2:0]; tdata: data_word[13:0], pin_level[14]
// m_axis   | out | tdata: drive_enable, data_bit, word_valid, read_word, match;
//          |     | tlast: last slot of the command's run
//
// One slot per cycle while m_axis_tready allows: a load emits 6+WORD_BITS+2 slots,
// other commands 6, a sample 1 (none without a pending read); the serializer unit in the back end sets this.
// A two-entry command queue takes new transfers while a command serializes.
// The output register holds a slot while m_axis_tready is low.
// Reset is synchronous, active low; no clearing pass.
module icsp_programming_serializer_core #(
    parameter int WORD_BITS = icsp_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [13:0] data_word, [14] pin_level, [15] zero
    input  logic [icsp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] drive_enable, [1] data_bit, [2] word_valid, [16:3] read_word,
    // [17] match, [23:18] zero
    output logic [icsp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import icsp_pkg::*;

    logic   q_valid;
    t_item  q_item;
    logic   q_pop;
    t_slot  slot;

    icsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    icsp_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_slot_valid (m_axis_tvalid),
        .i_slot_ready (m_axis_tready),
        .o_slot       (slot)
    );

    assign m_axis_tdata = {
        (OUT_TDATA_W - DATA_W - 4)'(0),
        slot.match,
        slot.read_word,
        slot.word_valid,
        slot.data_bit,
        slot.drive_enable
    };
    assign m_axis_tlast = slot.last;

endmodule

// File: src/icsp_front.sv
module icsp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [icsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [2:0]                          s_axis_tuser,
    output logic                                o_q_valid,
    output icsp_pkg::t_item                     o_q_item,
    input  logic                                i_q_pop
);
    import icsp_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_q [Q_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               accept;
    logic               push;
    logic               pop;
    t_item              in_item;

    assign s_axis_tready = (r_cnt != CNT_W'(Q_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_item.op   = t_op'(s_axis_tuser);
        in_item.word = s_axis_tdata[DATA_W-1:0];
        in_item.pin  = s_axis_tdata[DATA_W];
    end

    // drop the unused operation code here
    assign push      = accept && (s_axis_tuser != 3'd7);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(Q_DEPTH)) && !i_q_pop |=> (r_cnt == CNT_W'(Q_DEPTH)))
        else $error("full queue changed without a pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) || (r_cnt == CNT_W'(Q_DEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");

endmodule

// File: src/icsp_back.sv
module icsp_back #(
    parameter int WORD_BITS = icsp_pkg::WORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  icsp_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    output logic             o_slot_valid,
    input  logic             i_slot_ready,
    output icsp_pkg::t_slot  o_slot
);
    import icsp_pkg::*;

    localparam int CNT_W  = $clog2(CMD_BITS + WORD_BITS + 2);
    localparam int RCNT_W = $clog2(WORD_BITS + 2);

    localparam logic [CNT_W-1:0]  CMD_LAST  = CNT_W'(CMD_BITS - 1);
    localparam logic [CNT_W-1:0]  START_BIT = CNT_W'(CMD_BITS);
    localparam logic [CNT_W-1:0]  DATA_END  = CNT_W'(CMD_BITS + WORD_BITS);
    localparam logic [CNT_W-1:0]  LOAD_LAST = CNT_W'(CMD_BITS + WORD_BITS + 1);
    localparam logic [RCNT_W-1:0] RD_STOP   = RCNT_W'(WORD_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_bstate;

    t_bstate                r_state, n_state;
    t_op                    r_op, n_op;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CMD_BITS-2:0]    r_code, n_code;
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic [WORD_BITS-1:0]   r_loaded, n_loaded;
    logic [WORD_BITS-1:0]   r_rshift, n_rshift;
    logic [RCNT_W-1:0]      r_rcnt, n_rcnt;
    logic                   r_pend, n_pend;
    logic                   r_ovalid, n_ovalid;
    t_slot                  r_oslot, n_oslot;
    logic                   out_can;
    logic                   emit;
    t_slot                  slot;
    logic [CMD_BITS-1:0]    code;
    logic                   is_load;

    assign out_can = !r_ovalid || i_slot_ready;
    assign code    = cmd_code(i_q_item.op);
    assign is_load = (r_op == OP_LOAD_CFG) || (r_op == OP_LOAD_DATA);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_code   = r_code;
        n_word   = r_word;
        n_loaded = r_loaded;
        n_rshift = r_rshift;
        n_rcnt   = r_rcnt;
        n_pend   = r_pend;
        o_q_pop  = 1'b0;
        emit     = 1'b0;
        slot     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.op)
                        OP_SAMPLE: begin
                            if (!r_pend) begin
                                o_q_pop = 1'b1;
                            end else if (out_can) begin
                                o_q_pop   = 1'b1;
                                emit      = 1'b1;
                                slot.last = 1'b1;
                                if (r_rcnt >= RD_STOP) begin
                                    slot.word_valid = 1'b1;
                                    slot.read_word  = DATA_W'(r_rshift);
                                    slot.match      = (r_rshift == r_loaded);
                                    n_pend          = 1'b0;
                                    n_rcnt          = '0;
                                end else begin
                                    if (r_rcnt != '0) begin
                                        n_rshift = {i_q_item.pin, r_rshift[WORD_BITS-1:1]};
                                    end
                                    n_rcnt = r_rcnt + 1'b1;
                                end
                            end
                        end
                        OP_LOAD_CFG, OP_LOAD_DATA, OP_READ_DATA,
                        OP_INCREMENT, OP_ERASE_PROG, OP_BULK_ERASE: begin
                            if (out_can) begin
                                o_q_pop           = 1'b1;
                                emit              = 1'b1;
                                slot.drive_enable = 1'b1;
                                slot.data_bit     = code[0];
                                n_code            = code[CMD_BITS-1:1];
                                n_word            = WORD_BITS'(i_q_item.word);
                                n_op              = i_q_item.op;
                                n_cnt             = CNT_W'(1);
                                n_state           = ST_RUN;
                                n_pend            = 1'b0;
                                n_rcnt            = '0;
                                if (i_q_item.op == OP_LOAD_DATA) begin
                                    n_loaded = WORD_BITS'(i_q_item.word);
                                end
                                if (i_q_item.op == OP_READ_DATA) begin
                                    n_pend   = 1'b1;
                                    n_rshift = '0;
                                end
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_can) begin
                    emit              = 1'b1;
                    slot.drive_enable = 1'b1;
                    if (r_cnt <= CMD_LAST) begin
                        slot.data_bit = r_code[0];
                        n_code        = r_code >> 1;
                    end else if (r_cnt == START_BIT) begin
                        slot.data_bit = 1'b0;
                    end else if (r_cnt <= DATA_END) begin
                        slot.data_bit = r_word[0];
                        n_word        = r_word >> 1;
                    end else begin
                        slot.data_bit = 1'b0;
                    end
                    slot.last = is_load ? (r_cnt == LOAD_LAST) : (r_cnt == CMD_LAST);
                    if (slot.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        n_oslot  = r_oslot;
        if (emit) begin
            n_ovalid = 1'b1;
            n_oslot  = slot;
        end else if (i_slot_ready) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_slot_valid = r_ovalid;
    assign o_slot       = r_oslot;

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_code  <= n_code;
        r_word  <= n_word;
        r_oslot <= n_oslot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= '0;
            r_rshift <= '0;
            r_rcnt   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_rshift <= n_rshift;
            r_rcnt   <= n_rcnt;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend |-> (r_rcnt == '0))
        else $error("sample count left over without a pending read");

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RD_STOP)
        else $error("sample count past stop bit");

    a_word_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oslot.word_valid |-> !r_oslot.drive_enable && r_oslot.last)
        else $error("read word reported on a driven or inner slot");

    a_no_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_q_pop)
        else $error("queue popped while a command is in flight");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import icsp_pkg::*;

    localparam int WORD_BITS = WORD_BITS_DEF;
    localparam logic [2:0] OP_INVALID = 3'd7;

    localparam logic [CMD_BITS-1:0] CODE_LOAD_CFG   = 6'h00;
    localparam logic [CMD_BITS-1:0] CODE_LOAD_DATA  = 6'h02;
    localparam logic [CMD_BITS-1:0] CODE_READ_DATA  = 6'h04;
    localparam logic [CMD_BITS-1:0] CODE_INCREMENT  = 6'h06;
    localparam logic [CMD_BITS-1:0] CODE_ERASE_PROG = 6'h08;
    localparam logic [CMD_BITS-1:0] CODE_BULK_ERASE = 6'h09;

    typedef enum int {CHK_PREDICT, CHK_NONE, CHK_WORD} t_check;

    typedef struct {
        logic [2:0]        op;
        logic [DATA_W-1:0] word;
        logic              pin;
        int                reps;
        t_check            chk;
        logic [DATA_W-1:0] exp_word;
        logic              exp_match;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [13:0] data_word, [14] pin_level, [15] zero
    logic [2:0]             s_axis_tuser;   // [2:0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // drive_enable, data_bit, word_valid,
                                            // read_word[13:0], match
    logic                   m_axis_tlast;

    logic [DATA_W-1:0] prog_word;
    logic [DATA_W-1:0] rd_shift;
    logic [4:0]        rd_count;
    logic              rd_busy;

    t_slot cmd_slots [$];
    t_slot slots_due [$];
    int    mismatches = 0;
    int    live_cmds = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_req = 1'b0;
    int    hold_left = 0;

    t_row dir_rows [12] = '{
        '{OP_SAMPLE,     14'h0000, 1'b1, 1,  CHK_NONE,    14'h0000, 1'b0},
        '{OP_INVALID,    14'h3fff, 1'b1, 1,  CHK_NONE,    14'h0000, 1'b0},
        '{OP_LOAD_DATA,  14'h3fff, 1'b0, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_LOAD_CFG,   14'h0000, 1'b1, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_INCREMENT,  14'h2aaa, 1'b0, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_ERASE_PROG, 14'h1555, 1'b1, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_BULK_ERASE, 14'h0000, 1'b0, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_READ_DATA,  14'h0000, 1'b0, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_SAMPLE,     14'h0000, 1'b1, 15, CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_SAMPLE,     14'h3fff, 1'b1, 1,  CHK_WORD,    14'h3fff, 1'b1},
        '{OP_READ_DATA,  14'h3fff, 1'b1, 1,  CHK_PREDICT, 14'h0000, 1'b0},
        '{OP_SAMPLE,     14'h0000, 1'b1, 1,  CHK_PREDICT, 14'h0000, 1'b0}
    };

    icsp_programming_serializer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void serialize_command(input logic [2:0] op,
                                              input logic [DATA_W-1:0] w,
                                              input logic p);
        logic [CMD_BITS-1:0] code;
        t_slot               s;
        int                  i;
        cmd_slots.delete();
        s = '0;
        code = CODE_LOAD_CFG;
        if (op == OP_INVALID)
            return;
        if (op == OP_SAMPLE) begin
            if (!rd_busy)
                return;
            if (rd_count >= 1 && rd_count <= WORD_BITS)
                rd_shift = rd_shift | (DATA_W'(p) << (rd_count - 5'd1));
            s.last = 1'b1;
            if (rd_count >= WORD_BITS + 1) begin
                s.word_valid = 1'b1;
                s.read_word  = rd_shift;
                s.match      = (rd_shift == prog_word);
                rd_busy      = 1'b0;
                rd_count     = '0;
            end else begin
                rd_count = rd_count + 5'd1;
            end
            cmd_slots.push_back(s);
            return;
        end
        // drop any read still waiting for samples
        rd_busy = 1'b0;
        case (op)
            OP_LOAD_CFG:   code = CODE_LOAD_CFG;
            OP_LOAD_DATA:  code = CODE_LOAD_DATA;
            OP_READ_DATA:  code = CODE_READ_DATA;
            OP_INCREMENT:  code = CODE_INCREMENT;
            OP_ERASE_PROG: code = CODE_ERASE_PROG;
            OP_BULK_ERASE: code = CODE_BULK_ERASE;
            default:       code = CODE_LOAD_CFG;
        endcase
        s.drive_enable = 1'b1;
        for (i = 0; i < CMD_BITS; i++) begin
            s.data_bit = code[i];
            cmd_slots.push_back(s);
        end
        if (op == OP_LOAD_CFG || op == OP_LOAD_DATA) begin
            if (op == OP_LOAD_DATA)
                prog_word = w;
            s.data_bit = 1'b0;
            cmd_slots.push_back(s);
            for (i = 0; i < WORD_BITS; i++) begin
                s.data_bit = w[i];
                cmd_slots.push_back(s);
            end
            s.data_bit = 1'b0;
            cmd_slots.push_back(s);
        end else if (op == OP_READ_DATA) begin
            rd_busy  = 1'b1;
            rd_count = '0;
            rd_shift = '0;
        end
        s = cmd_slots.pop_back();
        s.last = 1'b1;
        cmd_slots.push_back(s);
    endfunction

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_slot();
        t_slot want;
        if (slots_due.size() == 0) begin
            $error("unexpected transfer: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
            mismatches++;
            return;
        end
        want = slots_due.pop_front();
        cmp_field("drive_enable", want.drive_enable, m_axis_tdata[0]);
        cmp_field("data_bit", want.data_bit, m_axis_tdata[1]);
        cmp_field("word_valid", want.word_valid, m_axis_tdata[2]);
        cmp_field("read_word", want.read_word, m_axis_tdata[16:3]);
        cmp_field("match", want.match, m_axis_tdata[17]);
        cmp_field("last", want.last, m_axis_tlast);
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return DATA_W'($urandom_range(16383));
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [DATA_W-1:0] w,
                             input logic p, input t_check chk,
                             input logic [DATA_W-1:0] exp_word, input logic exp_match);
        t_slot s;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, p, w};
        do @(posedge i_clk); while (!s_axis_tready);
        serialize_command(op, w, p);
        if (cmd_slots.size() != 0)
            live_cmds++;
        if (chk == CHK_PREDICT) begin
            foreach (cmd_slots[k])
                slots_due.push_back(cmd_slots[k]);
        end else if (chk == CHK_WORD) begin
            s = '0;
            s.word_valid = 1'b1;
            s.read_word  = exp_word;
            s.match      = exp_match;
            s.last       = 1'b1;
            slots_due.push_back(s);
        end
        @(negedge i_clk);
    endtask

    task automatic random_sequence();
        int                pick;
        int                n;
        int                k;
        logic [DATA_W-1:0] w;
        logic              p;
        pick = $urandom_range(99);
        w = random_word();
        if (pick < 40) begin
            if ($urandom_range(1))
                w = prog_word;
            n = ($urandom_range(4) == 0) ? $urandom_range(1, 15) : WORD_BITS + 2;
            send_item(OP_READ_DATA, DATA_W'($urandom_range(16383)), 1'($urandom_range(1)),
                      CHK_PREDICT, '0, 1'b0);
            for (k = 0; k < n; k++) begin
                p = 1'($urandom_range(1));
                if (k >= 1 && k <= WORD_BITS)
                    p = w[k-1];
                send_item(OP_SAMPLE, DATA_W'($urandom_range(16383)), p,
                          CHK_PREDICT, '0, 1'b0);
            end
        end else if (pick < 65) begin
            send_item(OP_LOAD_DATA, w, 1'($urandom_range(1)), CHK_PREDICT, '0, 1'b0);
        end else if (pick < 75) begin
            send_item(OP_LOAD_CFG, w, 1'($urandom_range(1)), CHK_PREDICT, '0, 1'b0);
        end else if (pick < 90) begin
            send_item(3'($urandom_range(OP_INCREMENT, OP_BULK_ERASE)), w,
                      1'($urandom_range(1)), CHK_PREDICT, '0, 1'b0);
        end else if (pick < 95) begin
            send_item(OP_SAMPLE, w, 1'($urandom_range(1)), CHK_PREDICT, '0, 1'b0);
        end else begin
            send_item(OP_INVALID, w, 1'($urandom_range(1)), CHK_PREDICT, '0, 1'b0);
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                check_slot();
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 400;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int ph;
        int r;
        int target;
        int waited;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        prog_word     = '0;
        rd_shift      = '0;
        rd_count      = '0;
        rd_busy       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            for (r = 0; r < dir_rows[i].reps; r++)
                send_item(dir_rows[i].op, dir_rows[i].word, dir_rows[i].pin,
                          dir_rows[i].chk, dir_rows[i].exp_word, dir_rows[i].exp_match);
        end
        // a command cuts the pending read short; the next sample is dropped
        send_item(OP_INCREMENT, 14'h0000, 1'b0, CHK_PREDICT, '0, 1'b0);
        send_item(OP_SAMPLE, 14'h3fff, 1'b1, CHK_NONE, '0, 1'b0);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            target = live_cmds + 102;
            while (live_cmds < target)
                random_sequence();
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (slots_due.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && slots_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (slots_due.size() != 0)
                $error("%0d expected transfers never arrived", slots_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
